/* rtl/neighbor_table_upsert_assert.svh */
// assertion macros shared by the neighbor table modules
// no dependencies; included inside module bodies
`ifndef NEIGHBOR_TABLE_UPSERT_ASSERT_SVH
`define NEIGHBOR_TABLE_UPSERT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define NTU_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ntu assertion failed");

// next-cycle implication, disabled while reset is low
`define NTU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ntu assertion failed");

`endif

/* rtl/ntu_pkg.sv */
// shared types and constants of the neighbor table block
// no dependencies
package ntu_pkg;

    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned RSSI_W  = 8;
    localparam int unsigned SLOT_W  = 4;
    localparam int unsigned COUNT_W = 5;

    // slot_index and neighbor_count widths are sized for this depth
    localparam int unsigned TABLE_DEPTH = 16;

    localparam logic [ADDR_W-1:0] BROADCAST_ADDR = 16'hFFFF;

    // classified frame handed from front to back
    typedef struct packed {
        logic                     bcast;
        logic [ADDR_W-1:0]        src;
        logic signed [RSSI_W-1:0] rssi;
    } t_cmd;

    // one result beat
    typedef struct packed {
        logic               reply_request;
        logic [ADDR_W-1:0]  reply_address;
        logic               found_existing;
        logic               new_entry;
        logic               table_full_drop;
        logic [SLOT_W-1:0]  slot_index;
        logic [COUNT_W-1:0] neighbor_count;
    } t_res;

endpackage

/* rtl/ntu_front.sv */
// front end: accepts frames, classifies broadcast, queues them for the back end
// depends on ntu_pkg and neighbor_table_upsert_assert.svh
module ntu_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [ntu_pkg::ADDR_W-1:0] i_dest_address,
    input  logic [ntu_pkg::ADDR_W-1:0] i_source_address,
    input  logic signed [ntu_pkg::RSSI_W-1:0] i_signal_strength,
    output logic                       o_cmd_valid,
    input  logic                       i_cmd_ready,
    output ntu_pkg::t_cmd              o_cmd
);
    import ntu_pkg::*;
    `include "neighbor_table_upsert_assert.svh"

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned FILL_W      = $clog2(QUEUE_DEPTH + 1);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [PTR_W-1:0]  r_rp, n_rp;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              w_push, w_pop;
    t_cmd              w_cmd;

    always_comb begin
        w_cmd.bcast = (i_dest_address == BROADCAST_ADDR);
        w_cmd.src   = i_source_address;
        w_cmd.rssi  = i_signal_strength;
    end

    assign o_ready     = (r_fill != FILL_W'(QUEUE_DEPTH));
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_fill != '0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_mem[r_rp];

    always_comb begin
        n_wp   = w_push ? r_wp + 1'b1 : r_wp;
        n_rp   = w_pop ? r_rp + 1'b1 : r_rp;
        n_fill = r_fill;
        if (w_push && !w_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (w_pop && !w_push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            r_wp   <= n_wp;
            r_rp   <= n_rp;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_cmd;
        end
    end

    `NTU_ASSERT_NOW(a_fill_max, i_clk, i_rst_n, 1'b1, r_fill <= FILL_W'(QUEUE_DEPTH))
    `NTU_ASSERT_NEXT(a_fill_up, i_clk, i_rst_n, w_push && !w_pop, r_fill == $past(r_fill) + 1'b1)
    `NTU_ASSERT_NEXT(a_fill_dn, i_clk, i_rst_n, w_pop && !w_push, r_fill == $past(r_fill) - 1'b1)

endmodule

/* rtl/ntu_back.sv */
// back end: sequential table search, update/append/drop, bcast reply, result register
// depends on ntu_pkg and neighbor_table_upsert_assert.svh
module ntu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  ntu_pkg::t_cmd i_cmd,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output ntu_pkg::t_res o_res
);
    import ntu_pkg::*;
    `include "neighbor_table_upsert_assert.svh"

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SRCH = 3'b010,
        S_UPD  = 3'b100
    } t_bstate;

    t_bstate          r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0] r_cmp_idx, n_cmp_idx;
    logic             r_hit, n_hit;
    logic [IDX_W-1:0] r_where, n_where;
    logic             r_out_valid, n_out_valid;
    t_res             r_res, n_res;

    logic [ADDR_W-1:0]        r_addr_mem [TABLE_DEPTH];
    logic signed [RSSI_W-1:0] r_rssi_mem [TABLE_DEPTH];
    logic [ADDR_W-1:0]        r_rd_data;

    logic             w_issue;
    logic             w_out_free;
    logic             w_rd_en;
    logic             w_addr_we;
    logic             w_rssi_we;
    logic [IDX_W-1:0] w_wr_idx;
    logic             w_room;

    assign w_issue    = (r_idx < r_count);
    assign w_out_free = !r_out_valid || i_res_ready;
    assign w_room     = (r_count < CNT_W'(TABLE_DEPTH));
    assign w_rd_en    = (r_state == S_SRCH) && w_issue;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_count     = r_count;
        n_idx       = r_idx;
        n_cmp_vld   = r_cmp_vld;
        n_cmp_idx   = r_cmp_idx;
        n_hit       = r_hit;
        n_where     = r_where;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        o_cmd_ready = 1'b0;
        w_addr_we   = 1'b0;
        w_rssi_we   = 1'b0;
        w_wr_idx    = r_where;

        if (r_out_valid && i_res_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_cmd     = i_cmd;
                    n_idx     = '0;
                    n_hit     = 1'b0;
                    n_where   = '0;
                    n_cmp_vld = 1'b0;
                    n_state   = i_cmd.bcast ? S_UPD : S_SRCH;
                end
            end
            S_SRCH: begin
                // read one entry per beat, compare the one read a beat earlier
                n_cmp_vld = w_issue;
                n_cmp_idx = r_idx[IDX_W-1:0];
                if (w_issue) begin
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_state = S_UPD;
                end
                // later hits override, so the highest index wins
                if (r_cmp_vld && (r_rd_data == r_cmd.src)) begin
                    n_hit   = 1'b1;
                    n_where = r_cmp_idx;
                end
            end
            S_UPD: begin
                if (w_out_free) begin
                    n_out_valid           = 1'b1;
                    n_state               = S_IDLE;
                    n_res.reply_request   = 1'b0;
                    n_res.reply_address   = '0;
                    n_res.found_existing  = 1'b0;
                    n_res.new_entry       = 1'b0;
                    n_res.table_full_drop = 1'b0;
                    n_res.slot_index      = '0;
                    if (r_cmd.bcast) begin
                        n_res.reply_request = 1'b1;
                        n_res.reply_address = r_cmd.src;
                    end else if (r_hit) begin
                        w_rssi_we            = 1'b1;
                        w_wr_idx             = r_where;
                        n_res.found_existing = 1'b1;
                        n_res.slot_index     = SLOT_W'(r_where);
                    end else if (w_room) begin
                        w_addr_we        = 1'b1;
                        w_rssi_we        = 1'b1;
                        w_wr_idx         = r_count[IDX_W-1:0];
                        n_res.new_entry  = 1'b1;
                        n_res.slot_index = SLOT_W'(r_count[IDX_W-1:0]);
                        n_count          = r_count + 1'b1;
                    end else begin
                        n_res.table_full_drop = 1'b1;
                    end
                    n_res.neighbor_count = COUNT_W'(n_count);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_cmp_vld   <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_cmp_vld   <= n_cmp_vld;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_cmp_idx <= n_cmp_idx;
        r_where   <= n_where;
        r_res     <= n_res;
    end

    // neighbor table storage
    always_ff @(posedge i_clk) begin
        if (w_addr_we) begin
            r_addr_mem[w_wr_idx] <= r_cmd.src;
        end
        if (w_rssi_we) begin
            r_rssi_mem[w_wr_idx] <= r_cmd.rssi;
        end
        if (w_rd_en) begin
            r_rd_data <= r_addr_mem[r_idx[IDX_W-1:0]];
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_res;

    `NTU_ASSERT_NOW(a_cnt_max, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(TABLE_DEPTH))
    `NTU_ASSERT_NOW(a_idx_max, i_clk, i_rst_n, 1'b1, r_idx <= r_count)
    `NTU_ASSERT_NOW(a_one_kind, i_clk, i_rst_n, r_out_valid,
                    $onehot({r_res.reply_request, r_res.found_existing, r_res.new_entry,
                             r_res.table_full_drop}))
    `NTU_ASSERT_NEXT(a_append, i_clk, i_rst_n,
                     (r_state == S_UPD) && w_out_free && !r_cmd.bcast && !r_hit && w_room,
                     r_count == $past(r_count) + 1'b1)
    `NTU_ASSERT_NOW(a_cnt_hold, i_clk, i_rst_n, r_state == S_SRCH, r_count == $past(r_count))

endmodule

/* rtl/neighbor_table_upsert.sv */
// neighbor table upsert, top level: front queue plus back search/update engine
// the back end takes one frame at a time; broadcasts skip the search, while lookups
// walk the address table through its single read port, one entry per cycle, and up
// to two more frames wait in the front queue
// reset: synchronous active low; clears the entry count, the queue and the result valid
// depends on ntu_pkg, ntu_front, ntu_back
module neighbor_table_upsert (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // dest_address[15:0], source_address[31:16], signal_strength[39:32]
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // reply_address[15:0], slot_index[19:16], neighbor_count[24:20], zero[31:25]
    output logic [31:0] m_axis_tdata,
    // reply_request[0], found_existing[1], new_entry[2], table_full_drop[3]
    output logic [3:0]  m_axis_tuser
);
    import ntu_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    t_cmd cmd;
    t_res res;

    ntu_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (s_axis_tvalid),
        .o_ready           (s_axis_tready),
        .i_dest_address    (s_axis_tdata[15:0]),
        .i_source_address  (s_axis_tdata[31:16]),
        .i_signal_strength (s_axis_tdata[39:32]),
        .o_cmd_valid       (cmd_valid),
        .i_cmd_ready       (cmd_ready),
        .o_cmd             (cmd)
    );

    ntu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    assign m_axis_tdata = {7'd0, res.neighbor_count, res.slot_index, res.reply_address};
    assign m_axis_tuser = {res.table_full_drop, res.new_entry, res.found_existing,
                           res.reply_request};

endmodule
